[hdl/abcb_pkg.sv]
package abcb_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_DEST_WIDTH    = 3'd0;
    localparam logic [2:0] REG_DEST_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_DEST_STRIDE   = 3'd2;
    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd3;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd4;
    localparam logic [2:0] REG_OFFSET_X      = 3'd5;
    localparam logic [2:0] REG_OFFSET_Y      = 3'd6;

    // Register reset values.
    localparam logic [12:0] RST_DEST_WIDTH    = 13'd640;
    localparam logic [12:0] RST_DEST_HEIGHT   = 13'd480;
    localparam logic [12:0] RST_DEST_STRIDE   = 13'd640;
    localparam logic [12:0] RST_SOURCE_WIDTH  = 13'd1;
    localparam logic [12:0] RST_SOURCE_HEIGHT = 13'd1;
    localparam logic [12:0] RST_OFFSET_ZERO   = 13'd0;

    // Largest source size that the 12-bit counters can walk.
    localparam int CNT_LIMIT = 4096;

    // Full set of configuration registers. Offsets are two's complement.
    typedef struct packed {
        logic [12:0] dest_width;
        logic [12:0] dest_height;
        logic [12:0] dest_stride;
        logic [12:0] source_width;
        logic [12:0] source_height;
        logic [12:0] offset_x;
        logic [12:0] offset_y;
    } t_cfg;

    // Destination position of the current pixel and its end-of-rectangle flag.
    typedef struct packed {
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic               last;
    } t_pos;

    // Exact floor(v / 255) for v up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'd1 + 17'(v[15:8]);
        return t[15:8];
    endfunction

endpackage

[hdl/abcb_regs.sv]
module abcb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    output abcb_pkg::t_cfg     o_cfg
);

    abcb_pkg::t_cfg r_cfg;

    // Register file; indexes past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_width    <= abcb_pkg::RST_DEST_WIDTH;
            r_cfg.dest_height   <= abcb_pkg::RST_DEST_HEIGHT;
            r_cfg.dest_stride   <= abcb_pkg::RST_DEST_STRIDE;
            r_cfg.source_width  <= abcb_pkg::RST_SOURCE_WIDTH;
            r_cfg.source_height <= abcb_pkg::RST_SOURCE_HEIGHT;
            r_cfg.offset_x      <= abcb_pkg::RST_OFFSET_ZERO;
            r_cfg.offset_y      <= abcb_pkg::RST_OFFSET_ZERO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                abcb_pkg::REG_DEST_WIDTH:    r_cfg.dest_width    <= i_cfg_data;
                abcb_pkg::REG_DEST_HEIGHT:   r_cfg.dest_height   <= i_cfg_data;
                abcb_pkg::REG_DEST_STRIDE:   r_cfg.dest_stride   <= i_cfg_data;
                abcb_pkg::REG_SOURCE_WIDTH:  r_cfg.source_width  <= i_cfg_data;
                abcb_pkg::REG_SOURCE_HEIGHT: r_cfg.source_height <= i_cfg_data;
                abcb_pkg::REG_OFFSET_X:      r_cfg.offset_x      <= i_cfg_data;
                abcb_pkg::REG_OFFSET_Y:      r_cfg.offset_y      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/abcb_scan.sv]
module abcb_scan #(
    parameter int MAX_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  abcb_pkg::t_cfg     i_cfg,
    output abcb_pkg::t_pos     o_pos
);

    localparam int LIM = (MAX_DIM < abcb_pkg::CNT_LIMIT) ? MAX_DIM : abcb_pkg::CNT_LIMIT;
    localparam logic [12:0] LIM_W = 13'(LIM);

    logic [11:0] r_col, r_row;
    logic [11:0] n_col, n_row;
    logic [12:0] sw, sh;
    logic        col_end, row_end;

    // Effective source size: zero acts as one, large values clamp to the limit.
    always_comb begin
        if (i_cfg.source_width == 13'd0) begin
            sw = 13'd1;
        end else if (i_cfg.source_width > LIM_W) begin
            sw = LIM_W;
        end else begin
            sw = i_cfg.source_width;
        end
        if (i_cfg.source_height == 13'd0) begin
            sh = 13'd1;
        end else if (i_cfg.source_height > LIM_W) begin
            sh = LIM_W;
        end else begin
            sh = i_cfg.source_height;
        end
    end

    assign col_end = (13'(r_col) + 13'd1) >= sw;
    assign row_end = (13'(r_row) + 13'd1) >= sh;

    // Raster walk over the source rectangle.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (col_end) begin
                n_col = 12'd0;
                n_row = row_end ? 12'd0 : r_row + 12'd1;
            end else begin
                n_col = r_col + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 12'd0;
            r_row <= 12'd0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Destination position of the current pixel.
    assign o_pos.x    = 14'($signed(i_cfg.offset_x)) + $signed({2'b00, r_col});
    assign o_pos.y    = 14'($signed(i_cfg.offset_y)) + $signed({2'b00, r_row});
    assign o_pos.last = col_end && row_end;

endmodule

[hdl/abcb_blend.sv]
module abcb_blend (
    input  logic [31:0]        i_source_pixel,
    input  logic [31:0]        i_dest_pixel,
    input  abcb_pkg::t_pos     i_pos,
    input  abcb_pkg::t_cfg     i_cfg,
    output logic               o_write_enable,
    output logic [23:0]        o_dest_address,
    output logic [23:0]        o_blended_value
);

    logic [7:0]  alpha, alpha_inv;
    logic        in_bounds;
    logic [25:0] row_base;
    logic [15:0] sum_r, sum_g, sum_b;
    logic [23:0] addr, value;

    assign alpha     = i_source_pixel[31:24];
    assign alpha_inv = 8'd255 - alpha;

    // Clip against the destination surface.
    assign in_bounds = !i_pos.x[13] && !i_pos.y[13] &&
                       (i_pos.x[12:0] < i_cfg.dest_width) &&
                       (i_pos.y[12:0] < i_cfg.dest_height);

    assign o_write_enable = in_bounds && (alpha != 8'd0);

    // Linear address, wrapped to 24 bits.
    assign row_base = 26'(i_pos.y[12:0]) * 26'(i_cfg.dest_stride);
    assign addr     = row_base[23:0] + 24'(i_pos.x[12:0]);

    // Per-channel blend; full alpha reduces to the source channel exactly.
    assign sum_r = 16'(i_source_pixel[23:16]) * 16'(alpha) +
                   16'(i_dest_pixel[23:16]) * 16'(alpha_inv);
    assign sum_g = 16'(i_source_pixel[15:8]) * 16'(alpha) +
                   16'(i_dest_pixel[15:8]) * 16'(alpha_inv);
    assign sum_b = 16'(i_source_pixel[7:0]) * 16'(alpha) +
                   16'(i_dest_pixel[7:0]) * 16'(alpha_inv);
    assign value = {abcb_pkg::div255(sum_r), abcb_pkg::div255(sum_g),
                    abcb_pkg::div255(sum_b)};

    // Address and value read as zero when nothing is written.
    assign o_dest_address  = o_write_enable ? addr  : 24'd0;
    assign o_blended_value = o_write_enable ? value : 24'd0;

endmodule

[hdl/alpha_blend_clipped_blit_top.sv]
// An accepted word waits in the input register, moves on into the output
// register once that is free, and is taken from there. Throughput: one
// pixel per cycle while the output side is ready; the input register feeds
// the blend and address logic, whose result lands in the output register.
// Reset (synchronous, active low): registers return to their defaults, the
// scan counters to zero, and both pipeline stages are emptied.
module alpha_blend_clipped_blit_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_source_pixel,
    input  logic [31:0] i_dest_pixel,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_write_enable,
    output logic [23:0] o_dest_address,
    output logic [23:0] o_blended_value,
    output logic        o_last_pixel
);

    abcb_pkg::t_cfg cfg;
    abcb_pkg::t_pos pos;

    logic        in_accept, s1_move, out_free;
    logic        r_s1_valid, r_out_valid;
    logic [31:0] r_s1_src, r_s1_dst;
    abcb_pkg::t_pos r_s1_pos;
    logic        blk_we;
    logic [23:0] blk_addr, blk_value;
    logic        r_we, r_last;
    logic [23:0] r_addr, r_value;

    abcb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    abcb_scan #(.MAX_DIM(MAX_DIM)) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_accept),
        .i_cfg     (cfg),
        .o_pos     (pos)
    );

    // Handshake: each stage moves when the one after it is free.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_src <= i_source_pixel;
            r_s1_dst <= i_dest_pixel;
            r_s1_pos <= pos;
        end
    end

    abcb_blend u_blend (
        .i_source_pixel  (r_s1_src),
        .i_dest_pixel    (r_s1_dst),
        .i_pos           (r_s1_pos),
        .i_cfg           (cfg),
        .o_write_enable  (blk_we),
        .o_dest_address  (blk_addr),
        .o_blended_value (blk_value)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_we    <= blk_we;
            r_addr  <= blk_addr;
            r_value <= blk_value;
            r_last  <= r_s1_pos.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_enable  = r_we;
    assign o_dest_address  = r_addr;
    assign o_blended_value = r_value;
    assign o_last_pixel    = r_last;

`ifndef SYNTHESIS
    // A word without a write carries zero address and value.
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_enable) |-> (o_dest_address == 24'd0 &&
                                              o_blended_value == 24'd0))
        else $error("non-write word carries nonzero payload");

    // A filled input stage always drains into an empty output register.
    a_s1_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("input stage failed to drain into empty output");

    // Reset leaves the output empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 8;
    // Index past the last register; the block must ignore writes to it.
    localparam logic [2:0] REG_NONE = 3'd7;

    // One output word of the block.
    typedef struct packed {
        logic        we;
        logic [23:0] addr;
        logic [23:0] rgb;
        logic        last;
    } t_blit_word;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [2:0]  i_cfg_index    = '0;
    logic [12:0] i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_source_pixel = '0;
    logic [31:0] i_dest_pixel   = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic        o_write_enable;
    logic [23:0] o_dest_address;
    logic [23:0] o_blended_value;
    logic        o_last_pixel;

    // Shadow copy of the register file and of the scan counters.
    abcb_pkg::t_cfg cfg_now = '{
        dest_width:    abcb_pkg::RST_DEST_WIDTH,
        dest_height:   abcb_pkg::RST_DEST_HEIGHT,
        dest_stride:   abcb_pkg::RST_DEST_STRIDE,
        source_width:  abcb_pkg::RST_SOURCE_WIDTH,
        source_height: abcb_pkg::RST_SOURCE_HEIGHT,
        offset_x:      abcb_pkg::RST_OFFSET_ZERO,
        offset_y:      abcb_pkg::RST_OFFSET_ZERO
    };
    logic [11:0] scan_col = '0;
    logic [11:0] scan_row = '0;

    t_blit_word predicted_words[$];
    t_blit_word seen_word;

    int cycle_count   = 0;
    int fail_count    = 0;
    int pixels_sent   = 0;
    int words_checked = 0;
    int writes_seen   = 0;
    int reg_setups    = 0;

    // Traffic shaping knobs.
    int tx_burst_left = 0;
    int tx_gap_max    = 0;
    int rx_stall_pct  = 0;
    int rx_run_left   = 0;
    bit rx_stalling   = 1'b0;

    alpha_blend_clipped_blit_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_source_pixel (i_source_pixel),
        .i_dest_pixel   (i_dest_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_write_enable (o_write_enable),
        .o_dest_address (o_dest_address),
        .o_blended_value(o_blended_value),
        .o_last_pixel   (o_last_pixel)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Output side stalls in runs of random length, alternating with ready runs.
    always @(negedge i_clk) begin
        if (rx_run_left == 0) begin
            rx_stalling = ($urandom_range(99) < rx_stall_pct);
            rx_run_left = rx_stalling ? $urandom_range(1, 8) : $urandom_range(1, 12);
        end
        rx_run_left--;
        i_out_ready = !rx_stalling;
    end

    // Source rectangle sizes of zero act as one; oversize ones saturate.
    function automatic int span(input logic [12:0] v);
        if (v == 13'd0) return 1;
        if (int'(v) > abcb_pkg::CNT_LIMIT) return abcb_pkg::CNT_LIMIT;
        return int'(v);
    endfunction

    // Works out the word the block owes for one pixel and advances the scan.
    task automatic blend_and_place(input logic [31:0] src, input logic [31:0] dst);
        int         x, y, a, s, d, k;
        logic       col_end, row_end;
        t_blit_word w;
        w = '0;
        a = int'(src[31:24]);
        x = int'($signed(cfg_now.offset_x)) + int'(scan_col);
        y = int'($signed(cfg_now.offset_y)) + int'(scan_row);
        w.we = (x >= 0) && (y >= 0) && (x < int'(cfg_now.dest_width)) &&
               (y < int'(cfg_now.dest_height)) && (a != 0);
        if (w.we) begin
            w.addr = 24'(y * int'(cfg_now.dest_stride) + x);
            if (a == 255) begin
                w.rgb = src[23:0];
            end else begin
                for (k = 0; k < 3; k++) begin
                    s = int'(src[8*k +: 8]);
                    d = int'(dst[8*k +: 8]);
                    w.rgb[8*k +: 8] = 8'((s * a + d * (255 - a)) / 255);
                end
            end
        end
        col_end = (int'(scan_col) + 1) >= span(cfg_now.source_width);
        row_end = (int'(scan_row) + 1) >= span(cfg_now.source_height);
        w.last = col_end && row_end;
        if (col_end) begin
            scan_col = '0;
            scan_row = row_end ? 12'd0 : scan_row + 12'd1;
        end else begin
            scan_col = scan_col + 12'd1;
        end
        predicted_words.push_back(w);
    endtask

    // Result checking: every accepted word is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_words.size() == 0) begin
                $error("unexpected word: write_enable=%0b address=%h value=%h last=%0b",
                       o_write_enable, o_dest_address, o_blended_value, o_last_pixel);
                fail_count++;
            end else begin
                seen_word = predicted_words.pop_front();
                words_checked++;
                if (o_write_enable === 1'b1) writes_seen++;
                if (o_write_enable !== seen_word.we) begin
                    $error("write_enable mismatch: expected %0b, got %0b",
                           seen_word.we, o_write_enable);
                    fail_count++;
                end
                if (o_dest_address !== seen_word.addr) begin
                    $error("dest_address mismatch: expected %h, got %h",
                           seen_word.addr, o_dest_address);
                    fail_count++;
                end
                if (o_blended_value !== seen_word.rgb) begin
                    $error("blended_value mismatch: expected %h, got %h",
                           seen_word.rgb, o_blended_value);
                    fail_count++;
                end
                if (o_last_pixel !== seen_word.last) begin
                    $error("last_pixel mismatch: expected %0b, got %0b",
                           seen_word.last, o_last_pixel);
                    fail_count++;
                end
            end
        end
    end

    // Called at a falling edge. Leaves valid high so a burst can continue.
    task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
        int gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        tx_burst_left--;
        i_source_pixel = src;
        i_dest_pixel   = dst;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        blend_and_place(src, dst);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Stops the input and lets every outstanding word drain out.
    task automatic wait_idle();
        i_in_valid    = 1'b0;
        tx_burst_left = 0;
        while (predicted_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes the registers selected by mask; bit 7 pokes the unused index.
    task automatic program_regs(input abcb_pkg::t_cfg setup, input logic [7:0] mask);
        logic [12:0] data;
        int          idx;
        wait_idle();
        for (idx = 0; idx < 8; idx++) begin
            if (mask[idx]) begin
                unique case (3'(idx))
                    abcb_pkg::REG_DEST_WIDTH: begin
                        data = setup.dest_width;
                        cfg_now.dest_width = data;
                    end
                    abcb_pkg::REG_DEST_HEIGHT: begin
                        data = setup.dest_height;
                        cfg_now.dest_height = data;
                    end
                    abcb_pkg::REG_DEST_STRIDE: begin
                        data = setup.dest_stride;
                        cfg_now.dest_stride = data;
                    end
                    abcb_pkg::REG_SOURCE_WIDTH: begin
                        data = setup.source_width;
                        cfg_now.source_width = data;
                    end
                    abcb_pkg::REG_SOURCE_HEIGHT: begin
                        data = setup.source_height;
                        cfg_now.source_height = data;
                    end
                    abcb_pkg::REG_OFFSET_X: begin
                        data = setup.offset_x;
                        cfg_now.offset_x = data;
                    end
                    abcb_pkg::REG_OFFSET_Y: begin
                        data = setup.offset_y;
                        cfg_now.offset_y = data;
                    end
                    REG_NONE: begin
                        data = 13'($urandom);
                    end
                endcase
                i_cfg_we    = 1'b1;
                i_cfg_index = 3'(idx);
                i_cfg_data  = data;
                @(negedge i_clk);
            end
        end
        i_cfg_we = 1'b0;
        reg_setups++;
    endtask

    // Alpha is biased toward the copy and skip cases.
    function automatic logic [31:0] random_argb();
        logic [31:0] p;
        p = $urandom;
        case ($urandom_range(3))
            0: p[31:24] = 8'h00;
            1: p[31:24] = 8'hFF;
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic [12:0] pick_surface_dim();
        case ($urandom_range(9))
            0: return 13'd1;
            1: return 13'd4096;
            2, 3: return 13'($urandom_range(1, 4096));
            default: return 13'($urandom_range(1, 48));
        endcase
    endfunction

    // Reset defaults: a 1x1 rectangle at the origin, so every word is last.
    task automatic test_defaults();
        send_pixel(32'hFF12_3456, 32'h0000_0000);
        send_pixel(32'h00AB_CDEF, 32'hFFFF_FFFF);
    endtask

    // Alpha extremes and channel extremes over a 4x2 rectangle.
    task automatic test_blend_extremes();
        abcb_pkg::t_cfg setup;
        setup = cfg_now;
        setup.source_width  = 13'd4;
        setup.source_height = 13'd2;
        setup.offset_x      = 13'd3;
        setup.offset_y      = 13'd5;
        program_regs(setup, 8'h7F);
        send_pixel(32'hFF00_0000, 32'hFFFF_FFFF);
        send_pixel(32'h01FF_FFFF, 32'h0000_0000);
        send_pixel(32'hFEFF_FFFF, 32'h0000_0000);
        send_pixel(32'h8012_34AB, 32'h00FE_DCBA);
        send_pixel(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'h40A5_5A0F, 32'hFF5A_A5F0);
    endtask

    // Clipping against a 1x1 surface, far offsets, and an empty surface.
    task automatic test_clipping();
        abcb_pkg::t_cfg setup;
        int             k;
        setup = cfg_now;
        setup.dest_width    = 13'd1;
        setup.dest_height   = 13'd1;
        setup.dest_stride   = 13'd1;
        setup.source_width  = 13'd2;
        setup.source_height = 13'd2;
        setup.offset_x      = 13'd0;
        setup.offset_y      = 13'd0;
        program_regs(setup, 8'h7F);
        for (k = 0; k < 4; k++) send_pixel(32'hFF55_AA33, 32'h0000_0000);

        setup.source_width  = 13'd1;
        setup.source_height = 13'd1;
        setup.offset_x      = 13'h1000;
        setup.offset_y      = 13'h0FFF;
        program_regs(setup, 8'h7F);
        send_pixel(32'hFF11_2233, 32'h0044_5566);

        setup.dest_width  = 13'd0;
        setup.dest_height = 13'd0;
        setup.offset_x    = 13'd0;
        setup.offset_y    = 13'd0;
        program_regs(setup, 8'h7F);
        send_pixel(32'hFFC0_FFEE, 32'h0012_3456);
    endtask

    // Size saturation and counters left beyond a shrunken rectangle.
    task automatic test_counter_wrap();
        abcb_pkg::t_cfg setup;
        int             k;
        setup = cfg_now;
        setup.dest_width    = abcb_pkg::RST_DEST_WIDTH;
        setup.dest_height   = abcb_pkg::RST_DEST_HEIGHT;
        setup.dest_stride   = abcb_pkg::RST_DEST_STRIDE;
        setup.source_width  = 13'd0;
        setup.source_height = 13'd0;
        program_regs(setup, 8'h7F);
        send_pixel(random_argb(), $urandom);

        setup.source_width  = 13'h1FFF;
        setup.source_height = 13'd3;
        program_regs(setup, 8'h18);
        for (k = 0; k < 3; k++) send_pixel(random_argb(), $urandom);

        // Column counter now sits past the new width.
        setup.source_width = 13'd2;
        program_regs(setup, 8'h08);
        send_pixel(32'hFF01_0203, $urandom);

        setup.source_width  = 13'd1;
        setup.source_height = 13'h1FFF;
        program_regs(setup, 8'h18);
        for (k = 0; k < 3; k++) send_pixel(random_argb(), $urandom);

        // Row counter now sits past the new height; the write to the unused
        // index must leave everything alone.
        setup.source_height = 13'd2;
        program_regs(setup, 8'h90);
        send_pixel(32'hFF04_0506, $urandom);
    endtask

    // Largest surface at its far corner, then a stride that overflows 24 bits.
    task automatic test_address_wrap();
        abcb_pkg::t_cfg setup;
        setup.dest_width    = 13'd4096;
        setup.dest_height   = 13'd4096;
        setup.dest_stride   = 13'd4096;
        setup.source_width  = 13'd1;
        setup.source_height = 13'd1;
        setup.offset_x      = 13'h0FFF;
        setup.offset_y      = 13'h0FFF;
        program_regs(setup, 8'h7F);
        send_pixel(32'hFFAB_CDEF, $urandom);

        setup.dest_stride = 13'h1FFF;
        program_regs(setup, 8'h04);
        send_pixel(32'h9A87_6543, 32'h00FE_DCBA);
    endtask

    // Random setups, each followed by whole rectangles and now and then a
    // broken one that leaves the counters mid-scan.
    task automatic test_random_blits();
        abcb_pkg::t_cfg setup;
        int             target, rects, n, r, k, ox, oy, sw, sh;
        logic [7:0]     mask;
        target = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < target) begin
            setup.dest_width  = pick_surface_dim();
            setup.dest_height = pick_surface_dim();
            setup.dest_stride = pick_surface_dim();
            if ($urandom_range(19) == 0) begin
                setup.source_width = 13'd0;
            end else if ($urandom_range(9) == 0) begin
                setup.source_width = 13'($urandom_range(1, 64));
            end else begin
                setup.source_width = 13'($urandom_range(1, 10));
            end
            setup.source_height = ($urandom_range(19) == 0) ? 13'd0 :
                                  13'($urandom_range(1, 8));
            sw = span(setup.source_width);
            sh = span(setup.source_height);
            case ($urandom_range(7))
                0: ox = -4096;
                1: ox = 4095;
                2: ox = int'($signed(13'($urandom)));
                default: ox = $urandom_range(0, int'(setup.dest_width) + sw + 4) - sw - 2;
            endcase
            case ($urandom_range(7))
                0: oy = -4096;
                1: oy = 4095;
                2: oy = int'($signed(13'($urandom)));
                default: oy = $urandom_range(0, int'(setup.dest_height) + sh + 4) - sh - 2;
            endcase
            setup.offset_x = 13'(ox);
            setup.offset_y = 13'(oy);
            mask = ($urandom_range(4) == 0) ? 8'($urandom_range(1, 255)) : 8'h7F;
            program_regs(setup, mask);

            case ($urandom_range(3))
                0: begin tx_gap_max = 0; rx_stall_pct = 0;  end
                1: begin tx_gap_max = 6; rx_stall_pct = 0;  end
                2: begin tx_gap_max = 0; rx_stall_pct = 40; end
                default: begin tx_gap_max = 4; rx_stall_pct = 25; end
            endcase

            // Rectangle size follows whatever the registers now hold.
            n = span(cfg_now.source_width) * span(cfg_now.source_height);
            rects = $urandom_range(1, 3);
            for (r = 0; r < rects; r++) begin
                k = ($urandom_range(6) == 0) ? $urandom_range(1, n) : n;
                repeat (k) send_pixel(random_argb(), $urandom);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        tx_gap_max   = 3;
        rx_stall_pct = 30;
        test_defaults();
        test_blend_extremes();
        test_clipping();
        test_counter_wrap();
        test_address_wrap();
        test_random_blits();
        wait_idle();

        $display("Blit run: %0d pixels sent, %0d words checked, %0d of them writes.",
                 pixels_sent, words_checked, writes_seen);
        $display("Covered %0d register setups, clipping on all edges and counter wraps.",
                 reg_setups);
        if (fail_count == 0 && predicted_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
